### hw/rtl/stable_priority_queue_core_defines.svh
// assertion macros used by the priority queue datapath
`ifndef STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SPQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion on the block clock and reset
`define SPQ_ASSERT(label, prop, msg) `SPQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/spq_pkg.sv
// types, constants and helpers of the stable priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PREP_W   = 8;
  localparam int unsigned FILL_W   = 7;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ID_W-1:0]         id_t;
  typedef logic [KIND_W-1:0]       kind_t;
  typedef logic [PREP_W-1:0]       prep_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef struct packed {
    key_t  key;
    id_t   id;
    kind_t kind;
    prep_t prep;
  } entry_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_INS_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_START,
    S_INS_CMP,
    S_INS_PLACE,
    S_POP_READ,
    S_RESP
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // latch the incoming beat
    logic rd_tail;  // read the entry just below the free slot
    logic shift;    // move the read entry up one slot and read the next one
    logic place;    // write the new entry into the free slot
    logic rd_head;  // read the head entry
    logic load;     // update the queue and load the result register
  } spq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic j_one;     // one entry left below the free slot
    logic greater;   // read entry key is above the new key
    logic out_free;  // result register can take a value this cycle
  } spq_sts_t;

  // ring pointer step up with wrap
  function automatic addr_t addr_inc(input addr_t a);
    addr_t r;
    r = (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    return r;
  endfunction

  // ring pointer step down with wrap
  function automatic addr_t addr_dec(input addr_t a);
    addr_t r;
    r = (a == '0) ? ADDR_W'(CAPACITY - 1) : a - 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/spq_in_if.sv
// input channel of the priority queue: operation beat
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  operation;
  key_t  priority_key;
  id_t   order_id;
  kind_t order_kind;
  prep_t order_prep;

  modport source (
    output valid, operation, priority_key, order_id, order_kind, order_prep,
    input  ready
  );

  modport sink (
    input  valid, operation, priority_key, order_id, order_kind, order_prep,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/spq_out_if.sv
// output channel of the priority queue: result beat
`default_nettype none

interface spq_out_if import spq_pkg::*; ();
  logic  valid;
  logic  ready;
  logic [1:0] status;
  key_t  out_key;
  id_t   out_id;
  kind_t out_kind;
  prep_t out_prep;
  fill_t fill_level;

  modport source (
    output valid, status, out_key, out_id, out_kind, out_prep, fill_level,
    input  ready
  );

  modport sink (
    input  valid, status, out_key, out_id, out_kind, out_prep, fill_level,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// controller state machine of the priority queue
`default_nettype none

module spq_ctrl import spq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     op_i,
  input  wire spq_sts_t sts_i,
  output logic          in_ready_o,
  output spq_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_INSERT) begin
            if (sts_i.full) begin
              state_d = S_RESP;
            end else if (sts_i.empty) begin
              state_d = S_INS_PLACE;
            end else begin
              state_d = S_INS_START;
            end
          end else begin
            state_d = sts_i.empty ? S_RESP : S_POP_READ;
          end
        end
      end
      S_INS_START: state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (!sts_i.greater) begin
          state_d = S_RESP;
        end else if (sts_i.j_one) begin
          state_d = S_INS_PLACE;
        end
      end
      S_INS_PLACE: state_d = S_RESP;
      S_POP_READ:  state_d = S_RESP;
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_INS_START: cmd_o.rd_tail = 1'b1;
      S_INS_CMP: begin
        cmd_o.shift = sts_i.greater;
        cmd_o.place = !sts_i.greater;
      end
      S_INS_PLACE: cmd_o.place   = 1'b1;
      S_POP_READ:  cmd_o.rd_head = 1'b1;
      S_RESP:      cmd_o.load    = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/spq_dpath.sv
// datapath of the priority queue: ring store, pointers and result register
`default_nettype none
`include "stable_priority_queue_core_defines.svh"

module spq_dpath import spq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire spq_cmd_t cmd_i,
  output spq_sts_t      sts_o,
  input  wire logic     op_i,
  input  wire key_t     key_i,
  input  wire id_t      id_i,
  input  wire kind_t    kind_i,
  input  wire prep_t    prep_i,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output logic [1:0]    status_o,
  output key_t          out_key_o,
  output id_t           out_id_o,
  output kind_t         out_kind_o,
  output prep_t         out_prep_o,
  output fill_t         fill_o
);

  localparam logic [CNT_W:0] CapWide = (CNT_W + 1)'(CAPACITY);

  entry_t  entry_mem_q [CAPACITY];
  entry_t  rd_q;
  entry_t  new_q;
  addr_t   head_q;
  addr_t   w_q;
  addr_t   r_q;
  cnt_t    count_q;
  cnt_t    j_q;
  cnt_t    count_next;
  status_e status_q;
  logic    out_valid_q;
  logic    [1:0] status_out_q;
  key_t    out_key_q;
  id_t     out_id_q;
  kind_t   out_kind_q;
  prep_t   out_prep_q;
  fill_t   fill_q;

  logic    [CNT_W:0] tail_sum;
  addr_t   tail_addr;
  addr_t   rd_addr;
  logic    rd_en;
  logic    wr_en;
  entry_t  wr_data;
  logic    full;
  logic    empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // physical slot just past the last held entry
  assign tail_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign tail_addr = (tail_sum >= CapWide) ? ADDR_W'(tail_sum - CapWide) : ADDR_W'(tail_sum);

  // memory port control
  assign rd_en   = cmd_i.rd_tail | cmd_i.shift | cmd_i.rd_head;
  assign rd_addr = cmd_i.rd_head ? head_q : (cmd_i.shift ? addr_dec(r_q) : r_q);
  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_data = cmd_i.shift ? rd_q : new_q;

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[w_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= entry_mem_q[rd_addr];
    end
  end

  // latched item and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      new_q <= '{key: key_i, id: id_i, kind: kind_i, prep: prep_i};
      w_q   <= tail_addr;
      r_q   <= addr_dec(tail_addr);
      j_q   <= count_q;
    end else if (cmd_i.shift) begin
      w_q <= r_q;
      r_q <= addr_dec(r_q);
      j_q <= j_q - 1'b1;
    end
  end

  // outcome of the beat, decided at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_INSERTED;
    end else if (cmd_i.accept) begin
      if (op_i == OP_INSERT) begin
        status_q <= full ? ST_INS_FULL : ST_INSERTED;
      end else begin
        status_q <= empty ? ST_POP_EMPTY : ST_POPPED;
      end
    end
  end

  // fill count after this beat
  always_comb begin
    case (status_q)
      ST_INSERTED: count_next = count_q + 1'b1;
      ST_POPPED:   count_next = count_q - 1'b1;
      default:     count_next = count_q;
    endcase
  end

  // head pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_next;
      if (status_q == ST_POPPED) begin
        head_q <= addr_inc(head_q);
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_out_q <= status_q;
      fill_q       <= FILL_W'(count_next);
      if (status_q == ST_POPPED) begin
        out_key_q  <= rd_q.key;
        out_id_q   <= rd_q.id;
        out_kind_q <= rd_q.kind;
        out_prep_q <= rd_q.prep;
      end else begin
        out_key_q  <= '0;
        out_id_q   <= '0;
        out_kind_q <= '0;
        out_prep_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_out_q;
  assign out_key_o   = out_key_q;
  assign out_id_o    = out_id_q;
  assign out_kind_o  = out_kind_q;
  assign out_prep_o  = out_prep_q;
  assign fill_o      = fill_q;

  // status to the controller
  assign sts_o.full     = full;
  assign sts_o.empty    = empty;
  assign sts_o.j_one    = (j_q == CNT_W'(1));
  assign sts_o.greater  = ($signed(rd_q.key) > $signed(new_q.key));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // checks
  `SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `SPQ_ASSERT(a_head_bound, head_q <= ADDR_W'(CAPACITY - 1), "head pointer out of range")
  `SPQ_ASSERT(a_insert_grows,
    cmd_i.load && status_q == ST_INSERTED |=> count_q == $past(count_q) + 1'b1,
    "insert did not grow the fill count")

endmodule

`default_nettype wire

### hw/rtl/stable_priority_queue_core.sv
// Stable priority queue: holds up to CAPACITY entries (key, id, kind, prep) in
// ascending signed key order in a ring-addressed single-port-write memory; equal
// keys leave in arrival order. Each input beat gives exactly one result beat.
// One operation is in flight at a time. A pop, a pop on an empty queue and an
// insert on a full one need no walk; an insert into a non-empty queue walks
// down from the tail, moving each held entry whose key is above the new key up
// one slot, one entry a cycle through the memory's one read port and one write
// port. A stalled result beat adds its stall time. No clearing pass after reset.
`default_nettype none

module stable_priority_queue_core import spq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  // sequencer
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.operation),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // store and result register
  spq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.operation),
    .key_i       (in_i.priority_key),
    .id_i        (in_i.order_id),
    .kind_i      (in_i.order_kind),
    .prep_i      (in_i.order_prep),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .out_key_o   (out_o.out_key),
    .out_id_o    (out_o.out_id),
    .out_kind_o  (out_o.out_kind),
    .out_prep_o  (out_o.out_prep),
    .fill_o      (out_o.fill_level)
  );

endmodule

`default_nettype wire
